/* src/sraq_pkg.sv */
// Shared types and constants for the selective-repeat sender window.
// Used by sraq_ctrl, sraq_dpath, sr_arq_sender_window, sraq_checker and tb; no dependencies.
package sraq_pkg;

    localparam int WINDOW_DEF  = 6;
    localparam int SEQ_SPACE   = 12;
    localparam int SACK_MAX    = 6;
    localparam int SACK_FIELDS = 6;

    localparam int SEQ_W    = 4;
    localparam int SLOT_W   = 3;
    localparam int CNT_O_W  = 3;
    localparam int FUNC_W   = 2;
    localparam int SCNT_W   = 3;
    localparam int TCMD_W   = 2;
    localparam int KEY_W    = $clog2(SACK_FIELDS + 1);
    localparam int SIDX_W   = $clog2(SACK_FIELDS);

    localparam logic [SEQ_W-1:0]  SEQ_LAST    = SEQ_W'(SEQ_SPACE - 1);
    localparam logic [SCNT_W-1:0] SACK_LIMIT  = SCNT_W'(SACK_MAX);
    localparam logic [SCNT_W-1:0] SACK_NFIELD = SCNT_W'(SACK_FIELDS);

    localparam logic [FUNC_W-1:0] FUNC_NEW     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ACK     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd2;

    typedef struct packed {
        logic             load;
        logic             new_msg;
        logic             ack_key;
        logic             slide;
        logic             timeout;
        logic             finish;
        logic [KEY_W-1:0] key_idx;
    } sraq_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              packet_ok;
        logic              key_last;
        logic              updated;
        logic              slide_more;
    } sraq_status_t;

    typedef struct packed {
        logic               send_valid;
        logic [SEQ_W-1:0]   send_seq;
        logic [SLOT_W-1:0]  send_slot;
        logic               is_resend;
        logic               win_refused;
        logic [TCMD_W-1:0]  timer_cmd;
        logic [CNT_O_W-1:0] acks_gained;
        logic [CNT_O_W-1:0] in_flight;
    } sraq_result_t;

endpackage

/* src/sr_arq_sender_window.sv */
// Selective-repeat sender window. New message, timeout, ignored ack and the spare
// function code go from dispatch straight to the result. A valid ack steps the
// primary ack and then each SACK entry, one a cycle, and then slides the window
// front one slot a cycle. A new beat is accepted once the previous result is in the
// output register, also while that output beat waits.
// Reset clears the window, sequence counter and timer flag; slot numbers load on use.
module sr_arq_sender_window
    import sraq_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FUNC_W-1:0]  func,
    input  logic               packet_ok,
    input  logic               ack_valid,
    input  logic [SEQ_W-1:0]   ack_seq,
    input  logic [SCNT_W-1:0]  sack_count,
    input  logic [SEQ_W-1:0]   sack_seq_0,
    input  logic [SEQ_W-1:0]   sack_seq_1,
    input  logic [SEQ_W-1:0]   sack_seq_2,
    input  logic [SEQ_W-1:0]   sack_seq_3,
    input  logic [SEQ_W-1:0]   sack_seq_4,
    input  logic [SEQ_W-1:0]   sack_seq_5,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               send_valid,
    output logic [SEQ_W-1:0]   send_seq,
    output logic [SLOT_W-1:0]  send_slot,
    output logic               is_resend,
    output logic               win_refused,
    output logic [TCMD_W-1:0]  timer_cmd,
    output logic [CNT_O_W-1:0] acks_gained,
    output logic [CNT_O_W-1:0] in_flight
);

    sraq_cmd_t                         cmd;
    sraq_status_t                      status;
    sraq_result_t                      result;
    sraq_result_t                      out_reg;
    logic                              out_valid_reg;
    logic                              out_free;
    logic                              out_load;
    logic [SACK_FIELDS-1:0][SEQ_W-1:0] sack_bus;

    assign sack_bus = {sack_seq_5, sack_seq_4, sack_seq_3,
                       sack_seq_2, sack_seq_1, sack_seq_0};

    assign out_free = !out_valid_reg || out_ready;

    sraq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .status   (status),
        .in_ready (in_ready),
        .out_load (out_load),
        .cmd      (cmd)
    );

    sraq_dpath #(
        .WINDOW (WINDOW)
    ) u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .func       (func),
        .packet_ok  (packet_ok),
        .ack_valid  (ack_valid),
        .ack_seq    (ack_seq),
        .sack_count (sack_count),
        .sack_seq   (sack_bus),
        .status     (status),
        .result     (result)
    );

    // output beat holds until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= result;
    end

    assign out_valid   = out_valid_reg;
    assign send_valid  = out_reg.send_valid;
    assign send_seq    = out_reg.send_seq;
    assign send_slot   = out_reg.send_slot;
    assign is_resend   = out_reg.is_resend;
    assign win_refused = out_reg.win_refused;
    assign timer_cmd   = out_reg.timer_cmd;
    assign acks_gained = out_reg.acks_gained;
    assign in_flight   = out_reg.in_flight;

endmodule

/* src/sraq_ctrl.sv */
// Sequencer for the sender window: dispatches each event, steps the ack keys,
// walks the window slide and hands the result to the output stage. Uses sraq_pkg.
module sraq_ctrl
    import sraq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         out_free,
    input  sraq_status_t status,
    output logic         in_ready,
    output logic         out_load,
    output sraq_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_ACK      = 3'd2;
    localparam logic [2:0] S_SLIDE    = 3'd3;
    localparam logic [2:0] S_DONE     = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [KEY_W-1:0] key_reg, key_next;

    always_comb
    begin
        state_next  = state_reg;
        key_next    = key_reg;
        in_ready    = 1'b0;
        out_load    = 1'b0;
        cmd         = '0;
        cmd.key_idx = key_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                key_next = '0;
                priority if (status.func == FUNC_NEW)
                begin
                    cmd.new_msg = 1'b1;
                    state_next  = S_DONE;
                end
                else if (status.func == FUNC_TIMEOUT)
                begin
                    cmd.timeout = 1'b1;
                    state_next  = S_DONE;
                end
                else if (status.func == FUNC_ACK && status.packet_ok)
                begin
                    state_next = S_ACK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_ACK:
            begin
                // one key per cycle: primary ack first, then each SACK entry
                cmd.ack_key = 1'b1;
                if (status.key_last)
                    state_next = S_SLIDE;
                else
                    key_next = key_reg + 1'b1;
            end
            S_SLIDE:
            begin
                if (status.updated && status.slide_more)
                    cmd.slide = 1'b1;
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            key_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

endmodule

/* src/sraq_dpath.sv */
// Window scoreboard datapath: slot ring, ack/timer marks, ring-order search
// and result assembly, driven by commands from sraq_ctrl. Uses sraq_pkg.
module sraq_dpath
    import sraq_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  sraq_cmd_t                           cmd,
    input  logic [FUNC_W-1:0]                   func,
    input  logic                                packet_ok,
    input  logic                                ack_valid,
    input  logic [SEQ_W-1:0]                    ack_seq,
    input  logic [SCNT_W-1:0]                   sack_count,
    input  logic [SACK_FIELDS-1:0][SEQ_W-1:0]   sack_seq,
    output sraq_status_t                        status,
    output sraq_result_t                        result
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam logic [IDX_W:0]   WIN_IDX  = (IDX_W + 1)'(WINDOW);
    localparam logic [CNT_W-1:0] WIN_CNT  = CNT_W'(WINDOW);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

    // window state
    logic [SEQ_W-1:0]  slot_seq_reg [WINDOW];
    logic [WINDOW-1:0] acked_reg;
    logic [WINDOW-1:0] timed_reg;
    logic [IDX_W-1:0]  oldest_reg;
    logic [IDX_W-1:0]  newest_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SEQ_W-1:0]  next_seq_reg;
    logic              timer_on_reg;
    logic              updated_reg;

    // latched event
    logic [FUNC_W-1:0]                 func_reg;
    logic                              packet_ok_reg;
    logic                              ack_valid_reg;
    logic [SEQ_W-1:0]                  ack_seq_reg;
    logic [SCNT_W-1:0]                 eff_cnt_reg;
    logic [SACK_FIELDS-1:0][SEQ_W-1:0] sack_reg;

    // result under construction
    logic               res_send_valid_reg;
    logic [SEQ_W-1:0]   res_send_seq_reg;
    logic [IDX_W-1:0]   res_send_slot_reg;
    logic               res_is_resend_reg;
    logic               res_win_refused_reg;
    logic               res_stopped_reg;
    logic               res_started_reg;
    logic [CNT_O_W-1:0] res_acks_gained_reg;

    logic [SCNT_W-1:0] eff_cnt_in;
    logic [SEQ_W-1:0]  key_want;
    logic              key_use;
    logic              key_primary;
    logic [SIDX_W-1:0] sack_idx;
    logic [IDX_W:0]    slot_off [WINDOW];
    logic [WINDOW-1:0] hit;
    logic              found_any;
    logic              found_hi;
    logic [IDX_W-1:0]  slot_hi;
    logic [IDX_W-1:0]  slot_lo;
    logic [IDX_W-1:0]  found_slot;
    logic              found_acked;
    logic              found_timed;
    logic [SEQ_W-1:0]  found_seq;
    logic              do_mark;
    logic              has_room;
    logic              restart;
    logic [IDX_W-1:0]  newest_inc;
    logic [IDX_W-1:0]  oldest_inc;
    logic [SEQ_W-1:0]  next_seq_inc;

    // an oversize SACK list is dropped whole; the fields cap the rest
    always_comb
    begin
        if (sack_count > SACK_LIMIT)
            eff_cnt_in = '0;
        else if (sack_count > SACK_NFIELD)
            eff_cnt_in = SACK_NFIELD;
        else
            eff_cnt_in = sack_count;
    end

    always_comb
    begin
        sack_idx = SIDX_W'(cmd.key_idx - 1'b1);
        if (cmd.key_idx == '0)
        begin
            key_want    = ack_seq_reg;
            key_use     = ack_valid_reg;
            key_primary = 1'b1;
        end
        else
        begin
            key_want    = sack_reg[sack_idx];
            key_use     = (SCNT_W'(cmd.key_idx) <= eff_cnt_reg);
            key_primary = 1'b0;
        end
    end

    // per-slot match; a slot is in the window when its ring offset is below the count
    always_comb
    begin
        for (int s = 0; s < WINDOW; s++)
        begin
            if (IDX_W'(s) >= oldest_reg)
                slot_off[s] = (IDX_W + 1)'(s) - {1'b0, oldest_reg};
            else
                slot_off[s] = (IDX_W + 1)'(s) + WIN_IDX - {1'b0, oldest_reg};
            if (slot_off[s] < (IDX_W + 1)'(count_reg))
            begin
                if (cmd.timeout)
                    hit[s] = !acked_reg[s];
                else
                    hit[s] = (slot_seq_reg[s] == key_want) && (key_primary || !acked_reg[s]);
            end
            else
                hit[s] = 1'b0;
        end
    end

    // first hit in ring order: slots at or past the oldest come before wrapped ones
    always_comb
    begin
        found_any = 1'b0;
        found_hi  = 1'b0;
        slot_hi   = '0;
        slot_lo   = '0;
        for (int s = WINDOW - 1; s >= 0; s--)
        begin
            if (hit[s])
            begin
                found_any = 1'b1;
                slot_lo   = IDX_W'(s);
                if (IDX_W'(s) >= oldest_reg)
                begin
                    found_hi = 1'b1;
                    slot_hi  = IDX_W'(s);
                end
            end
        end
        found_slot = found_hi ? slot_hi : slot_lo;
    end

    assign found_acked  = acked_reg[found_slot];
    assign found_timed  = timed_reg[found_slot];
    assign found_seq    = slot_seq_reg[found_slot];
    assign do_mark      = cmd.ack_key && key_use && found_any && !found_acked;
    assign has_room     = (count_reg < WIN_CNT);
    assign restart      = updated_reg && !timer_on_reg && (count_reg != '0);
    assign newest_inc   = (newest_reg == LAST_IDX) ? '0 : newest_reg + 1'b1;
    assign oldest_inc   = (oldest_reg == LAST_IDX) ? '0 : oldest_reg + 1'b1;
    assign next_seq_inc = (next_seq_reg == SEQ_LAST) ? '0 : next_seq_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acked_reg    <= '0;
            timed_reg    <= '0;
            oldest_reg   <= '0;
            newest_reg   <= LAST_IDX;
            count_reg    <= '0;
            next_seq_reg <= '0;
            timer_on_reg <= 1'b0;
            updated_reg  <= 1'b0;
        end
        else
        begin
            priority if (cmd.load)
            begin
                updated_reg <= 1'b0;
            end
            else if (cmd.new_msg)
            begin
                if (has_room)
                begin
                    newest_reg            <= newest_inc;
                    acked_reg[newest_inc] <= 1'b0;
                    timed_reg[newest_inc] <= 1'b1;
                    count_reg             <= count_reg + 1'b1;
                    next_seq_reg          <= next_seq_inc;
                    timer_on_reg          <= 1'b1;
                end
            end
            else if (do_mark)
            begin
                acked_reg[found_slot] <= 1'b1;
                updated_reg           <= 1'b1;
                if (found_timed)
                begin
                    timed_reg[found_slot] <= 1'b0;
                    timer_on_reg          <= 1'b0;
                end
            end
            else if (cmd.slide)
            begin
                oldest_reg <= oldest_inc;
                count_reg  <= count_reg - 1'b1;
            end
            else if (cmd.finish)
            begin
                if (restart)
                    timer_on_reg <= 1'b1;
            end
            else if (cmd.timeout)
            begin
                timer_on_reg <= found_any;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.new_msg && has_room)
            slot_seq_reg[newest_inc] <= next_seq_reg;

        priority if (cmd.load)
        begin
            func_reg            <= func;
            packet_ok_reg       <= packet_ok;
            ack_valid_reg       <= ack_valid;
            ack_seq_reg         <= ack_seq;
            eff_cnt_reg         <= eff_cnt_in;
            sack_reg            <= sack_seq;
            res_send_valid_reg  <= 1'b0;
            res_send_seq_reg    <= '0;
            res_send_slot_reg   <= '0;
            res_is_resend_reg   <= 1'b0;
            res_win_refused_reg <= 1'b0;
            res_stopped_reg     <= 1'b0;
            res_started_reg     <= 1'b0;
            res_acks_gained_reg <= '0;
        end
        else if (cmd.new_msg)
        begin
            if (has_room)
            begin
                res_send_valid_reg <= 1'b1;
                res_send_seq_reg   <= next_seq_reg;
                res_send_slot_reg  <= newest_inc;
                res_started_reg    <= !timer_on_reg;
            end
            else
                res_win_refused_reg <= 1'b1;
        end
        else if (do_mark)
        begin
            res_acks_gained_reg <= res_acks_gained_reg + 1'b1;
            if (found_timed)
                res_stopped_reg <= 1'b1;
        end
        else if (cmd.finish)
        begin
            if (restart)
                res_started_reg <= 1'b1;
        end
        else if (cmd.timeout)
        begin
            if (found_any)
            begin
                res_send_valid_reg <= 1'b1;
                res_send_seq_reg   <= found_seq;
                res_send_slot_reg  <= found_slot;
                res_is_resend_reg  <= 1'b1;
                res_started_reg    <= 1'b1;
            end
        end
    end

    assign status.func       = func_reg;
    assign status.packet_ok  = packet_ok_reg;
    assign status.key_last   = (cmd.key_idx == KEY_W'(eff_cnt_reg));
    assign status.updated    = updated_reg;
    assign status.slide_more = (count_reg != '0) && acked_reg[oldest_reg];

    assign result.send_valid  = res_send_valid_reg;
    assign result.send_seq    = res_send_seq_reg;
    assign result.send_slot   = SLOT_W'(res_send_slot_reg);
    assign result.is_resend   = res_is_resend_reg;
    assign result.win_refused = res_win_refused_reg;
    assign result.timer_cmd   = {res_stopped_reg, res_started_reg};
    assign result.acks_gained = res_acks_gained_reg;
    assign result.in_flight   = CNT_O_W'(count_reg);

endmodule

/* verif/sraq_checker.sv */
`timescale 1ns / 1ps
// Checker for sr_arq_sender_window: watches both channels, keeps its own copy
// of the sender window, predicts each result beat and compares it. Needs sraq_pkg.
module sraq_checker
    import sraq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [FUNC_W-1:0]  func,
    input  logic               packet_ok,
    input  logic               ack_valid,
    input  logic [SEQ_W-1:0]   ack_seq,
    input  logic [SCNT_W-1:0]  sack_count,
    input  logic [SEQ_W-1:0]   sack_seq_0,
    input  logic [SEQ_W-1:0]   sack_seq_1,
    input  logic [SEQ_W-1:0]   sack_seq_2,
    input  logic [SEQ_W-1:0]   sack_seq_3,
    input  logic [SEQ_W-1:0]   sack_seq_4,
    input  logic [SEQ_W-1:0]   sack_seq_5,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               send_valid,
    input  logic [SEQ_W-1:0]   send_seq,
    input  logic [SLOT_W-1:0]  send_slot,
    input  logic               is_resend,
    input  logic               win_refused,
    input  logic [TCMD_W-1:0]  timer_cmd,
    input  logic [CNT_O_W-1:0] acks_gained,
    input  logic [CNT_O_W-1:0] in_flight,
    output int                 fail_count,
    output int                 pending,
    output int                 n_results,
    output int                 n_full,
    output int                 n_resend,
    output logic [SEQ_W-1:0]   seq_head
);

    localparam logic [TCMD_W-1:0] TCMD_NONE  = 2'd0;
    localparam logic [TCMD_W-1:0] TCMD_START = 2'd1;
    localparam logic [TCMD_W-1:0] TCMD_STOP  = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]                   func;
        logic                                packet_ok;
        logic                                ack_valid;
        logic [SEQ_W-1:0]                    ack_seq;
        logic [SCNT_W-1:0]                   sack_count;
        logic [SACK_FIELDS-1:0][SEQ_W-1:0]   sacks;
    } sraq_item_t;

    // Window copy
    logic [SEQ_W-1:0] seq_mem [WINDOW_DEF];
    logic             acked   [WINDOW_DEF];
    logic             timed   [WINDOW_DEF];
    int               oldest;
    int               newest;
    int               cnt;
    logic [SEQ_W-1:0] nseq;
    logic             timer_on;

    sraq_result_t     due_q [$];

    assign seq_head = nseq;

    task automatic clear_window();
        for (int i = 0; i < WINDOW_DEF; i++)
        begin
            seq_mem[i] = '0;
            acked[i]   = 1'b0;
            timed[i]   = 1'b0;
        end
        oldest   = 0;
        newest   = WINDOW_DEF - 1;
        cnt      = 0;
        nseq     = '0;
        timer_on = 1'b0;
    endtask

    // Mark one slot acked; a set timer mark stops the timer.
    function automatic logic ack_slot(input int s);
        acked[s] = 1'b1;
        if (timed[s])
        begin
            timed[s] = 1'b0;
            timer_on = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic sraq_result_t apply_event(input sraq_item_t it);
        sraq_result_t r;
        logic         stop;
        logic         start;
        logic         changed;
        int           n;
        int           n_sack;
        int           s;
        r       = '0;
        stop    = 1'b0;
        start   = 1'b0;
        changed = 1'b0;
        n       = 0;
        case (it.func)
            FUNC_NEW:
            begin
                if (cnt < WINDOW_DEF)
                begin
                    newest          = (newest + 1) % WINDOW_DEF;
                    seq_mem[newest] = nseq;
                    acked[newest]   = 1'b0;
                    timed[newest]   = 1'b1;
                    cnt++;
                    r.send_valid    = 1'b1;
                    r.send_seq      = nseq;
                    r.send_slot     = SLOT_W'(newest);
                    if (!timer_on)
                    begin
                        timer_on = 1'b1;
                        start    = 1'b1;
                    end
                    nseq = (nseq == SEQ_LAST) ? '0 : nseq + 1'b1;
                end
                else
                    r.win_refused = 1'b1;
            end
            FUNC_ACK:
            begin
                if (it.packet_ok)
                begin
                    // primary ack hits the first slot with that number, acked or not
                    if (it.ack_valid)
                    begin
                        for (int i = 0; i < cnt; i++)
                        begin
                            s = (oldest + i) % WINDOW_DEF;
                            if (seq_mem[s] == it.ack_seq)
                            begin
                                if (!acked[s])
                                begin
                                    stop    = ack_slot(s) | stop;
                                    n++;
                                    changed = 1'b1;
                                end
                                break;
                            end
                        end
                    end
                    n_sack = (it.sack_count > SACK_LIMIT) ? 0 : int'(it.sack_count);
                    for (int j = 0; j < n_sack && j < SACK_FIELDS; j++)
                    begin
                        for (int i = 0; i < cnt; i++)
                        begin
                            s = (oldest + i) % WINDOW_DEF;
                            if (seq_mem[s] == it.sacks[j] && !acked[s])
                            begin
                                stop    = ack_slot(s) | stop;
                                n++;
                                changed = 1'b1;
                                break;
                            end
                        end
                    end
                    if (changed)
                    begin
                        while (cnt > 0 && acked[oldest])
                        begin
                            oldest = (oldest + 1) % WINDOW_DEF;
                            cnt--;
                        end
                        if (!timer_on)
                        begin
                            for (int i = 0; i < cnt; i++)
                            begin
                                if (!acked[(oldest + i) % WINDOW_DEF])
                                begin
                                    timer_on = 1'b1;
                                    start    = 1'b1;
                                    break;
                                end
                            end
                        end
                    end
                end
            end
            FUNC_TIMEOUT:
            begin
                timer_on = 1'b0;
                for (int i = 0; i < cnt; i++)
                begin
                    s = (oldest + i) % WINDOW_DEF;
                    if (!acked[s])
                    begin
                        r.send_valid = 1'b1;
                        r.send_seq   = seq_mem[s];
                        r.send_slot  = SLOT_W'(s);
                        r.is_resend  = 1'b1;
                        timer_on     = 1'b1;
                        start        = 1'b1;
                        break;
                    end
                end
            end
            default:
                ;
        endcase
        r.timer_cmd   = (stop ? TCMD_STOP : TCMD_NONE) | (start ? TCMD_START : TCMD_NONE);
        r.acks_gained = CNT_O_W'(n);
        r.in_flight   = CNT_O_W'(cnt);
        return r;
    endfunction

    function automatic string show_result(input sraq_result_t r);
        return $sformatf({"send=%0d seq=%0d slot=%0d resend=%0d full=%0d ",
                          "tcmd=%0d acks=%0d fly=%0d"},
                         r.send_valid, r.send_seq, r.send_slot, r.is_resend,
                         r.win_refused, r.timer_cmd, r.acks_gained, r.in_flight);
    endfunction

    task automatic check_result();
        sraq_result_t got;
        sraq_result_t want;
        logic         bad;
        got = {send_valid, send_seq, send_slot, is_resend, win_refused,
               timer_cmd, acks_gained, in_flight};
        n_results++;
        if (due_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("[%0t] result beat with nothing outstanding: %s",
                         $realtime, show_result(got));
        end
        else
        begin
            want = due_q.pop_front();
            bad  = (got.send_valid  !== want.send_valid)
                || (got.send_seq    !== want.send_seq)
                || (got.send_slot   !== want.send_slot)
                || (got.is_resend   !== want.is_resend)
                || (got.win_refused !== want.win_refused)
                || (got.timer_cmd   !== want.timer_cmd)
                || (got.acks_gained !== want.acks_gained)
                || (got.in_flight   !== want.in_flight);
            if (want.win_refused)
                n_full++;
            if (want.is_resend)
                n_resend++;
            if (bad)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("[%0t] mismatch on result %0d\n  expected %s\n  actual   %s",
                             $realtime, n_results, show_result(want), show_result(got));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_window();
            due_q.delete();
            pending    = 0;
            fail_count = 0;
            n_results  = 0;
            n_full     = 0;
            n_resend   = 0;
        end
        else
        begin
            // compare first: a beat accepted on this edge cannot be answered on it
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                due_q.push_back(apply_event({func, packet_ok, ack_valid, ack_seq, sack_count,
                                             sack_seq_5, sack_seq_4, sack_seq_3,
                                             sack_seq_2, sack_seq_1, sack_seq_0}));
            pending = due_q.size();
        end
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Testbench top for sr_arq_sender_window: clock, reset, directed and random
// event beats under several idle phases, and the verdict. Needs sraq_pkg and sraq_checker.
module tb;
    import sraq_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int EVENTS_PER_PHASE = 213;
    localparam logic [SACK_FIELDS-1:0][SEQ_W-1:0] NO_SACK = '0;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [FUNC_W-1:0]  func;
    logic               packet_ok;
    logic               ack_valid;
    logic [SEQ_W-1:0]   ack_seq;
    logic [SCNT_W-1:0]  sack_count;
    logic [SEQ_W-1:0]   sack_seq_0;
    logic [SEQ_W-1:0]   sack_seq_1;
    logic [SEQ_W-1:0]   sack_seq_2;
    logic [SEQ_W-1:0]   sack_seq_3;
    logic [SEQ_W-1:0]   sack_seq_4;
    logic [SEQ_W-1:0]   sack_seq_5;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               send_valid;
    logic [SEQ_W-1:0]   send_seq;
    logic [SLOT_W-1:0]  send_slot;
    logic               is_resend;
    logic               win_refused;
    logic [TCMD_W-1:0]  timer_cmd;
    logic [CNT_O_W-1:0] acks_gained;
    logic [CNT_O_W-1:0] in_flight;

    int                 fail_count;
    int                 pending;
    int                 n_results;
    int                 n_full;
    int                 n_resend;
    logic [SEQ_W-1:0]   seq_head;

    int                 idle_pct  = 0;
    int                 stall_pct = 0;
    int                 beats     = 0;

    sr_arq_sender_window dut (.*);
    sraq_checker chk (.*);

    always #1 clk = ~clk;

    always @(negedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= stall_pct);

    function automatic logic [SACK_FIELDS-1:0][SEQ_W-1:0] sack_list(
        input logic [SEQ_W-1:0] a, b, c, d, e, f);
        return {f, e, d, c, b, a};
    endfunction

    // Mostly numbers just behind the next sequence number, so acks land in the window.
    function automatic logic [SEQ_W-1:0] pick_seq();
        int back;
        back = $urandom_range(0, 6);
        if ($urandom_range(9) < 7)
            return SEQ_W'((int'(seq_head) + SEQ_SPACE - 1 - back) % SEQ_SPACE);
        return SEQ_W'($urandom_range(0, 15));
    endfunction

    task automatic send_event(input logic [FUNC_W-1:0] f, input logic ok, input logic av,
                              input logic [SEQ_W-1:0] aseq, input logic [SCNT_W-1:0] scnt,
                              input logic [SACK_FIELDS-1:0][SEQ_W-1:0] sl);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        func       <= f;
        packet_ok  <= ok;
        ack_valid  <= av;
        ack_seq    <= aseq;
        sack_count <= scnt;
        sack_seq_0 <= sl[0];
        sack_seq_1 <= sl[1];
        sack_seq_2 <= sl[2];
        sack_seq_3 <= sl[3];
        sack_seq_4 <= sl[4];
        sack_seq_5 <= sl[5];
        in_valid   <= 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        beats++;
    endtask

    task automatic random_event();
        int                pick;
        logic [FUNC_W-1:0] f;
        logic [SCNT_W-1:0] scnt;
        pick = $urandom_range(99);
        if (pick < 40)
            f = FUNC_NEW;
        else if (pick < 78)
            f = FUNC_ACK;
        else if (pick < 95)
            f = FUNC_TIMEOUT;
        else
            f = FUNC_SPARE;
        // now and then a count above the limit, which drops the whole list
        scnt = ($urandom_range(19) == 0) ? {SCNT_W{1'b1}} : SCNT_W'($urandom_range(0, SACK_MAX));
        send_event(f, $urandom_range(9) != 0, $urandom_range(6) != 0, pick_seq(), scnt,
                   sack_list(pick_seq(), pick_seq(), pick_seq(),
                             pick_seq(), pick_seq(), pick_seq()));
    endtask

    task automatic run_phase(input int sender_pct, input int receiver_pct);
        // hold off until every result is back, then switch idle rates
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
        idle_pct  = sender_pct;
        stall_pct = receiver_pct;
        repeat (EVENTS_PER_PHASE) random_event();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        func       = FUNC_NEW;
        packet_ok  = 1'b0;
        ack_valid  = 1'b0;
        ack_seq    = '0;
        sack_count = '0;
        sack_seq_0 = '0;
        sack_seq_1 = '0;
        sack_seq_2 = '0;
        sack_seq_3 = '0;
        sack_seq_4 = '0;
        sack_seq_5 = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // timeout, spare code and ack, all on an empty window
        send_event(FUNC_TIMEOUT, 1'b0, 1'b0, 4'd0, 3'd0, NO_SACK);
        send_event(FUNC_SPARE, 1'b1, 1'b1, 4'd15, {SCNT_W{1'b1}},
                   sack_list(4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15));
        send_event(FUNC_ACK, 1'b1, 1'b1, 4'd0, 3'd0, NO_SACK);
        // fill the window, then one more is refused
        repeat (7) send_event(FUNC_NEW, 1'b0, 1'b0, 4'd0, 3'd0, NO_SACK);
        // bad checksum drops an ack that would clear everything
        send_event(FUNC_ACK, 1'b0, 1'b1, 4'd0, 3'd6,
                   sack_list(4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5));
        // sack in the middle, then a primary ack on that already acked slot
        send_event(FUNC_ACK, 1'b1, 1'b0, 4'd0, 3'd1,
                   sack_list(4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0));
        send_event(FUNC_ACK, 1'b1, 1'b1, 4'd3, 3'd0, NO_SACK);
        send_event(FUNC_TIMEOUT, 1'b0, 1'b0, 4'd0, 3'd0, NO_SACK);
        // list over the limit is dropped, primary still slides the front
        send_event(FUNC_ACK, 1'b1, 1'b1, 4'd0, {SCNT_W{1'b1}},
                   sack_list(4'd1, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0));
        // full list with out-of-range numbers and a repeat
        send_event(FUNC_ACK, 1'b1, 1'b0, 4'd0, 3'd6,
                   sack_list(4'd1, 4'd2, 4'd4, 4'd15, 4'd12, 4'd2));
        send_event(FUNC_TIMEOUT, 1'b0, 1'b0, 4'd0, 3'd0, NO_SACK);
        send_event(FUNC_ACK, 1'b1, 1'b1, 4'd5, 3'd0, NO_SACK);
        send_event(FUNC_TIMEOUT, 1'b0, 1'b0, 4'd0, 3'd0, NO_SACK);
        // ring wraps to slot zero; ack out of order
        repeat (2) send_event(FUNC_NEW, 1'b0, 1'b0, 4'd0, 3'd0, NO_SACK);
        send_event(FUNC_ACK, 1'b1, 1'b1, 4'd7, 3'd0, NO_SACK);
        send_event(FUNC_ACK, 1'b1, 1'b1, 4'd6, 3'd0, NO_SACK);

        run_phase(0, 0);
        run_phase(47, 0);
        run_phase(0, 47);
        run_phase(32, 32);

        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (24) @(posedge clk);
        $display("Drove %0d event beats across four idle phases; checked %0d results,",
                 beats, n_results);
        $display("including %0d window-full refusals and %0d timeout resends.",
                 n_full, n_resend);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
src/sraq_pkg.sv
src/sraq_ctrl.sv
src/sraq_dpath.sv
src/sr_arq_sender_window.sv
verif/sraq_checker.sv
verif/tb.sv
